[hdl/dgt_pkg.sv]
// shared types and constants of the grid triangulator
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package dgt_pkg;

  // field widths fixed by the payload and register layout
  localparam int ELEV_W = 16;
  localparam int IDX_W  = 20;
  localparam int SIZE_W = 11;

  // register indexes (byte address bits 3:2)
  localparam logic [1:0] REG_NODATA   = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;
  localparam logic [1:0] REG_NUM_ROWS = 2'd2;

  // nodata reset value, -9999
  localparam logic [ELEV_W-1:0] NODATA_RESET = 16'hD8F1;

  // triangle select bits of a cell
  localparam int TRI_FIRST  = 0;
  localparam int TRI_SECOND = 1;

  // configuration seen by the datapath
  typedef struct packed {
    logic [ELEV_W-1:0] nodata;
    logic [SIZE_W-1:0] ncols;
    logic [SIZE_W-1:0] nrows;
    logic              restart;
  } cfg_t;

  // sample in flight between the line buffer stage and the emitter
  typedef struct packed {
    logic [ELEV_W-1:0] br;
    logic              has_cell;
    logic              row_end;
    logic [IDX_W-1:0]  i_br;
    logic [IDX_W-1:0]  i_tr;
  } samp_t;

endpackage

[hdl/dgt_stream_if.sv]
// valid/ready stream interfaces for samples in and triangles out
// depends on dgt_pkg for field widths
`timescale 1ns / 1ps

interface dgt_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [dgt_pkg::ELEV_W-1:0] elevation;

  modport source (output valid, output elevation, input ready);
  modport sink   (input valid, input elevation, output ready);
endinterface

interface dgt_out_if;
  logic                       valid;
  logic                       ready;
  logic [dgt_pkg::IDX_W-1:0]  vertex_a;
  logic [dgt_pkg::IDX_W-1:0]  vertex_b;
  logic [dgt_pkg::IDX_W-1:0]  vertex_c;
  logic                       last_of_run;

  modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                  output last_of_run, input ready);
  modport sink   (input valid, input vertex_a, input vertex_b, input vertex_c,
                  input last_of_run, output ready);
endinterface

[hdl/dgt_cfg.sv]
// apb register file: nodata value and clamped grid size
// depends on dgt_pkg for register indexes and cfg_t
`timescale 1ns / 1ps

module dgt_cfg #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output dgt_pkg::cfg_t                 cfg_o
);

  localparam int CLW = 18;
  localparam logic [CLW-1:0] MAXC = CLW'(MAX_COLS);
  localparam logic [CLW-1:0] MAXR = CLW'(MAX_ROWS);
  localparam logic [dgt_pkg::SIZE_W-1:0] NCOLS_RST =
    (MAX_COLS < 1024) ? dgt_pkg::SIZE_W'(MAX_COLS) : 11'd1024;
  localparam logic [dgt_pkg::SIZE_W-1:0] NROWS_RST =
    (MAX_ROWS < 1024) ? dgt_pkg::SIZE_W'(MAX_ROWS) : 11'd1024;

  logic [dgt_pkg::ELEV_W-1:0] nodata_q, nodata_d;
  logic [dgt_pkg::SIZE_W-1:0] ncols_q, ncols_d;
  logic [dgt_pkg::SIZE_W-1:0] nrows_q, nrows_d;
  logic                       wr_en;
  logic [1:0]                 reg_idx;

  // size clamp to 2..max
  function automatic logic [dgt_pkg::SIZE_W-1:0] clamp_size(
    input logic [dgt_pkg::SIZE_W-1:0] v,
    input logic [CLW-1:0]             mx
  );
    logic [dgt_pkg::SIZE_W-1:0] res;
    if (v < 11'd2) begin
      res = 11'd2;
    end else if (CLW'(v) > mx) begin
      res = mx[dgt_pkg::SIZE_W-1:0];
    end else begin
      res = v;
    end
    return res;
  endfunction

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // write decode
  always_comb begin
    nodata_d = nodata_q;
    ncols_d  = ncols_q;
    nrows_d  = nrows_q;
    if (wr_en) begin
      case (reg_idx)
        dgt_pkg::REG_NODATA:   nodata_d = pwdata[dgt_pkg::ELEV_W-1:0];
        dgt_pkg::REG_NUM_COLS: ncols_d  = clamp_size(pwdata[dgt_pkg::SIZE_W-1:0], MAXC);
        dgt_pkg::REG_NUM_ROWS: nrows_d  = clamp_size(pwdata[dgt_pkg::SIZE_W-1:0], MAXR);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodata_q <= dgt_pkg::NODATA_RESET;
      ncols_q  <= NCOLS_RST;
      nrows_q  <= NROWS_RST;
    end else begin
      nodata_q <= nodata_d;
      ncols_q  <= ncols_d;
      nrows_q  <= nrows_d;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      dgt_pkg::REG_NODATA:   prdata = {16'd0, nodata_q};
      dgt_pkg::REG_NUM_COLS: prdata = {21'd0, ncols_q};
      dgt_pkg::REG_NUM_ROWS: prdata = {21'd0, nrows_q};
      default:               prdata = 32'd0;
    endcase
  end

  // a size write restarts the frame at the same edge
  assign cfg_o.nodata  = nodata_q;
  assign cfg_o.ncols   = ncols_q;
  assign cfg_o.nrows   = nrows_q;
  assign cfg_o.restart = wr_en && (reg_idx == dgt_pkg::REG_NUM_COLS ||
                                   reg_idx == dgt_pkg::REG_NUM_ROWS);

endmodule

[hdl/dgt_line_stage.sv]
// input stage: grid position counters and the previous-row line buffer
// depends on dgt_pkg and dgt_in_if
`timescale 1ns / 1ps

module dgt_line_stage #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dgt_pkg::cfg_t               cfg_i,
  dgt_in_if.sink                      in_s,
  input  logic                        take_i,
  output logic                        valid_o,
  output dgt_pkg::samp_t              samp_o,
  output logic [dgt_pkg::ELEV_W-1:0]  tr_o
);

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CMPC = (CW + 1 > dgt_pkg::SIZE_W) ? CW + 1 : dgt_pkg::SIZE_W;
  localparam int CMPR = (RW + 1 > dgt_pkg::SIZE_W) ? RW + 1 : dgt_pkg::SIZE_W;

  logic [CW-1:0]               col_q, col_d;
  logic [RW-1:0]               row_q, row_d;
  logic [dgt_pkg::IDX_W-1:0]   sidx_q, sidx_d;
  logic                        valid_q, valid_d;
  dgt_pkg::samp_t              samp_q;
  logic [dgt_pkg::ELEV_W-1:0]  rd_q;
  logic [dgt_pkg::ELEV_W-1:0]  line_mem [MAX_COLS];
  logic                        acc;
  logic                        col_end;
  logic                        row_last;

  // stage register is free when empty or handed on this cycle
  assign in_s.ready = !valid_q || take_i;
  assign acc        = in_s.valid && in_s.ready;

  assign col_end  = (CMPC'(col_q) + CMPC'(1)) >= CMPC'(cfg_i.ncols);
  assign row_last = (CMPR'(row_q) + CMPR'(1)) >= CMPR'(cfg_i.nrows);

  // position and stage valid update per accepted sample; a restart returns to row 0, col 0
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    sidx_d  = sidx_q;
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (acc) begin
      valid_d = 1'b1;
      if (col_end) begin
        col_d = '0;
        if (row_last) begin
          row_d  = '0;
          sidx_d = '0;
        end else begin
          row_d  = row_q + RW'(1);
          sidx_d = sidx_q + 20'd1;
        end
      end else begin
        col_d  = col_q + CW'(1);
        sidx_d = sidx_q + 20'd1;
      end
    end
    if (cfg_i.restart) begin
      col_d  = '0;
      row_d  = '0;
      sidx_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sidx_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sidx_q  <= sidx_d;
      valid_q <= valid_d;
    end
  end

  // sample payload for the emitter
  always_ff @(posedge clk_i) begin
    if (acc) begin
      samp_q.br       <= in_s.elevation;
      samp_q.has_cell <= (row_q != '0) && (col_q != '0);
      samp_q.row_end  <= col_end;
      samp_q.i_br     <= sidx_q;
      samp_q.i_tr     <= sidx_q - dgt_pkg::IDX_W'(cfg_i.ncols);
    end
  end

  // line buffer: old entry read out, new sample written back in place
  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q            <= line_mem[col_q];
      line_mem[col_q] <= in_s.elevation;
    end
  end

  assign valid_o = valid_q;
  assign samp_o  = samp_q;
  assign tr_o    = rd_q;

`ifndef ASSERT_OFF
  // column counter never reaches the row length
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPC'(col_q) < CMPC'(cfg_i.ncols))
    else $error("column counter beyond row length");

  // a row end sample wraps the column to zero
  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && col_end) |=> (col_q == '0))
    else $error("column did not wrap at row end");
`endif

endmodule

[hdl/dgt_tri_emit.sv]
// triangle builder: nodata tests, two-entry triangle hold and output register
// depends on dgt_pkg and dgt_out_if
`timescale 1ns / 1ps

module dgt_tri_emit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dgt_pkg::cfg_t               cfg_i,
  input  logic                        valid_i,
  input  dgt_pkg::samp_t              samp_i,
  input  logic [dgt_pkg::ELEV_W-1:0]  tr_i,
  output logic                        take_o,
  dgt_out_if.source                   out_m
);

  logic [dgt_pkg::ELEV_W-1:0] left_prev_q, left_cur_q;
  logic [1:0]                 mask_q, mask_d, mask_new;
  logic [dgt_pkg::IDX_W-1:0]  i_tl_q, i_bl_q, i_br_q, i_tr_q;
  logic                       out_valid_q, out_valid_d;
  logic [dgt_pkg::IDX_W-1:0]  va_q, vb_q, vc_q;
  logic                       last_q;
  logic                       tl_ok, tr_ok, bl_ok, br_ok;
  logic                       out_load;
  logic                       hold_free;

  // corner tests against nodata
  assign tl_ok = left_prev_q != cfg_i.nodata;
  assign bl_ok = left_cur_q  != cfg_i.nodata;
  assign tr_ok = tr_i        != cfg_i.nodata;
  assign br_ok = samp_i.br   != cfg_i.nodata;

  always_comb begin
    mask_new = 2'b00;
    mask_new[dgt_pkg::TRI_FIRST]  = samp_i.has_cell && (tl_ok || bl_ok || br_ok);
    mask_new[dgt_pkg::TRI_SECOND] = samp_i.has_cell && (tl_ok || br_ok || tr_ok);
  end

  // handshake between hold register and output register
  assign out_load  = (mask_q != 2'b00) && (!out_valid_q || out_m.ready);
  assign hold_free = (mask_q == 2'b00) || (out_load && mask_q != 2'b11);
  assign take_o    = valid_i && hold_free;

  always_comb begin
    mask_d = mask_q;
    if (take_o) begin
      mask_d = mask_new;
    end else if (out_load) begin
      if (mask_q[dgt_pkg::TRI_FIRST]) begin
        mask_d[dgt_pkg::TRI_FIRST] = 1'b0;
      end else begin
        mask_d[dgt_pkg::TRI_SECOND] = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_m.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state and left-neighbor samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= 2'b00;
      out_valid_q <= 1'b0;
      left_prev_q <= '0;
      left_cur_q  <= '0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.restart) begin
        left_prev_q <= '0;
        left_cur_q  <= '0;
      end else if (take_o) begin
        left_prev_q <= samp_i.row_end ? '0 : tr_i;
        left_cur_q  <= samp_i.row_end ? '0 : samp_i.br;
      end
    end
  end

  // vertex indices of the cell
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      i_br_q <= samp_i.i_br;
      i_bl_q <= samp_i.i_br - 20'd1;
      i_tr_q <= samp_i.i_tr;
      i_tl_q <= samp_i.i_tr - 20'd1;
    end
  end

  // output register, first triangle before second
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      va_q   <= i_tl_q;
      last_q <= (mask_q != 2'b11);
      if (mask_q[dgt_pkg::TRI_FIRST]) begin
        vb_q <= i_bl_q;
        vc_q <= i_br_q;
      end else begin
        vb_q <= i_br_q;
        vc_q <= i_tr_q;
      end
    end
  end

  assign out_m.valid       = out_valid_q;
  assign out_m.vertex_a    = va_q;
  assign out_m.vertex_b    = vb_q;
  assign out_m.vertex_c    = vc_q;
  assign out_m.last_of_run = last_q;

`ifndef ASSERT_OFF
  // a triangle that is not last is followed at once by its partner
  a_run_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_m.valid && out_m.ready && !out_m.last_of_run) |=>
      (out_m.valid && out_m.vertex_a == $past(out_m.vertex_a)))
    else $error("second triangle of a run missing");

  // no new sample while both triangles are still held
  a_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mask_q == 2'b11) |-> !take_o)
    else $error("hold register overwritten");
`endif

endmodule

[hdl/dem_grid_triangulator_top.sv]
// Grid triangulator top level.
// Samples arrive on in_s (valid/ready, row-major order); each sample at row >= 1
// and column >= 1 closes a 2x2 cell and yields up to two triangles on out_m,
// one per transfer, first triangle before second, last_of_run on the last one.
// A triangle whose three corners all equal the nodata value is dropped.
// Throughput: one sample per cycle while out_m is ready and each sample yields
// at most one triangle, the single triangle output register being the limit;
// a sample yielding two holds back the next until its second leaves the hold.
// The line buffer is a one-port-write, one-read memory of MAX_COLS entries read
// at the sample's column as the sample is written. When out_m stalls, finished
// triangles wait in the output register and a two-entry hold, and in_s lowers
// ready once the line stage register holds a sample too. Reset clears counters
// and pipeline valids; registers return to nodata -9999 and a 1024 x 1024 grid
// (clamped to the maximums). The line buffer needs no clearing. Writing num_cols
// or num_rows restarts the frame at row 0, col 0. The user must write registers
// over apb only while the block is idle; the block does not enforce it.
// Depends on dgt_pkg, dgt_stream_if, dgt_cfg, dgt_line_stage, dgt_tri_emit.
`timescale 1ns / 1ps

module dem_grid_triangulator_top #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dgt_in_if.sink      in_s,
  dgt_out_if.source   out_m
);

  dgt_pkg::cfg_t               cfg;
  dgt_pkg::samp_t              samp;
  logic                        samp_valid;
  logic                        samp_take;
  logic [dgt_pkg::ELEV_W-1:0]  tr;

  // register file
  dgt_cfg #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // counters and line buffer
  dgt_line_stage #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_line (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .in_s    (in_s),
    .take_i  (samp_take),
    .valid_o (samp_valid),
    .samp_o  (samp),
    .tr_o    (tr)
  );

  // triangle construction and output
  dgt_tri_emit u_emit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (samp_valid),
    .samp_i  (samp),
    .tr_i    (tr),
    .take_o  (samp_take),
    .out_m   (out_m)
  );

endmodule
